>>> hdl/baro_pkg.sv
// baro_pkg: shared types, codes and constants of the barometer compensation core
package baro_pkg;

  // calibration register indexes
  typedef enum logic [2:0] {
    CFG_C1_SENS      = 3'd0,
    CFG_C2_OFFSET    = 3'd1,
    CFG_C3_SENS_TC   = 3'd2,
    CFG_C4_OFFSET_TC = 3'd3,
    CFG_C5_REF_TEMP  = 3'd4,
    CFG_C6_TEMP_COEF = 3'd5
  } cfg_idx_t;

  localparam logic [15:0] C1_RESET = 16'd40127;
  localparam logic [15:0] C2_RESET = 16'd36924;
  localparam logic [15:0] C3_RESET = 16'd23317;
  localparam logic [15:0] C4_RESET = 16'd23282;
  localparam logic [15:0] C5_RESET = 16'd33464;
  localparam logic [15:0] C6_RESET = 16'd28312;

  // 20.00 C reference and the -15.00 C knee, as offsets added to a = temp - 2000
  localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [19:0] TEMP_KNEE = 20'sd3500;

  localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
  localparam logic [16:0]        PRESS_MIN = 17'd1000;
  localparam logic [16:0]        PRESS_MAX = 17'd120000;

  typedef struct packed {
    logic [23:0] raw_press;
    logic [23:0] raw_temp;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [16:0]        press_centi;
    logic               out_of_range;
  } result_t;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } cal_t;

  // first-order terms, leaving the front end
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [18:0] a;      // temp - 2000
    logic signed [19:0] b;      // temp + 1500
    logic signed [19:0] temp1;
    logic signed [36:0] off;
    logic signed [36:0] sens;
    logic [17:0]        t2;
    logic               lt;     // below 20 C
    logic               lt2;    // below -15 C
  } front_t;

  // corrected terms, leaving the second-order stage
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [14:0] temp_centi;
    logic               temp_flag;
    logic signed [40:0] off_f;
    logic signed [40:0] sens_f;
  } corr_t;

endpackage

>>> hdl/baro_front.sv
// baro_front: dT, the four first-order products and the first-order terms
module baro_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  baro_pkg::cal_t    cal,
  input  logic              up_valid,
  input  baro_pkg::sample_t up,
  output logic              dn_valid,
  output baro_pkg::front_t  dn
);

  // stage a: temperature difference
  logic               va;
  logic signed [24:0] dt;
  logic [23:0]        d1_a;
  logic [25:0]        dt_w;

  assign dt_w = {2'b0, up.raw_temp} - {2'b0, cal.c5, 8'b0};

  // stage b: products
  logic               vb;
  logic signed [41:0] m_t;
  logic signed [41:0] m_off;
  logic signed [41:0] m_sens;
  logic signed [49:0] m_dd;
  logic [23:0]        d1_b;

  // stage c: first-order terms
  logic signed [18:0] a_w;
  logic signed [19:0] b_w;

  assign a_w = m_t[41:23];
  assign b_w = {a_w[18], a_w} + baro_pkg::TEMP_KNEE;

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      dn_valid <= 1'b0;
    end else if (en) begin
      va       <= up_valid;
      vb       <= va;
      dn_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt     <= dt_w[24:0];
      d1_a   <= up.raw_press;
      m_t    <= dt * $signed({1'b0, cal.c6});
      m_off  <= dt * $signed({1'b0, cal.c4});
      m_sens <= dt * $signed({1'b0, cal.c3});
      m_dd   <= dt * dt;
      d1_b   <= d1_a;
      dn.d1    <= d1_b;
      dn.a     <= a_w;
      dn.b     <= b_w;
      dn.temp1 <= {a_w[18], a_w} + baro_pkg::TEMP_REF;
      dn.off   <= {{2{m_off[41]}}, m_off[41:7]} + {5'b0, cal.c2, 16'b0};
      dn.sens  <= {{3{m_sens[41]}}, m_sens[41:8]} + {6'b0, cal.c1, 15'b0};
      dn.t2    <= m_dd[48:31];
      dn.lt    <= a_w[18];
      dn.lt2   <= b_w[19];
    end
  end

endmodule

>>> hdl/baro_corr.sv
// baro_corr: second-order correction, temperature clamp and corrected offset and sensitivity
module baro_corr (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             up_valid,
  input  baro_pkg::front_t up,
  output logic             dn_valid,
  output baro_pkg::corr_t  dn
);

  logic signed [18:0] a_in;
  logic signed [19:0] b_in;
  logic signed [37:0] sq_a;
  logic signed [39:0] sq_b;

  assign a_in = up.a;
  assign b_in = up.b;
  assign sq_a = a_in * a_in;
  assign sq_b = b_in * b_in;

  // stage d: squares and corrected temperature
  logic               vd;
  logic [34:0]        aa;
  logic [34:0]        bb;
  logic signed [19:0] temp2;
  logic signed [36:0] off_d;
  logic signed [36:0] sens_d;
  logic               lt_d;
  logic               lt2_d;
  logic [23:0]        d1_d;

  // stage e: correction terms
  logic [37:0] q5;
  logic [37:0] q7;
  logic [38:0] q11;
  logic [38:0] off2_w;
  logic [38:0] sens2_w;

  assign q5  = {3'b0, aa} + {1'b0, aa, 2'b0};
  assign q7  = {bb, 3'b0} - {3'b0, bb};
  assign q11 = {1'b0, bb, 3'b0} + {3'b0, bb, 1'b0} + {4'b0, bb};

  always_comb begin
    off2_w  = '0;
    sens2_w = '0;
    if (lt_d) begin
      off2_w  = {2'b0, q5[37:1]};
      sens2_w = {3'b0, q5[37:2]};
      if (lt2_d) begin
        off2_w  = off2_w + {1'b0, q7};
        sens2_w = sens2_w + {1'b0, q11[38:1]};
      end
    end
  end

  logic               ve;
  logic [38:0]        off2;
  logic [38:0]        sens2;
  logic signed [36:0] off_e;
  logic signed [36:0] sens_e;
  logic signed [14:0] temp_e;
  logic               tflag_e;
  logic [23:0]        d1_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd       <= 1'b0;
      ve       <= 1'b0;
      dn_valid <= 1'b0;
    end else if (en) begin
      vd       <= up_valid;
      ve       <= vd;
      dn_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa     <= sq_a[34:0];
      bb     <= sq_b[34:0];
      temp2  <= up.temp1 - (up.lt ? {2'b0, up.t2} : 20'd0);
      off_d  <= up.off;
      sens_d <= up.sens;
      lt_d   <= up.lt;
      lt2_d  <= up.lt2;
      d1_d   <= up.d1;

      off2   <= off2_w;
      sens2  <= sens2_w;
      off_e  <= off_d;
      sens_e <= sens_d;
      d1_e   <= d1_d;
      if (temp2 < baro_pkg::TEMP_MIN) begin
        temp_e  <= baro_pkg::TEMP_MIN;
        tflag_e <= 1'b1;
      end else if (temp2 > baro_pkg::TEMP_MAX) begin
        temp_e  <= baro_pkg::TEMP_MAX;
        tflag_e <= 1'b1;
      end else begin
        temp_e  <= temp2[14:0];
        tflag_e <= 1'b0;
      end

      // stage f: apply the corrections
      dn.d1         <= d1_e;
      dn.temp_centi <= temp_e;
      dn.temp_flag  <= tflag_e;
      dn.off_f      <= {{4{off_e[36]}}, off_e} - {2'b0, off2};
      dn.sens_f     <= {{4{sens_e[36]}}, sens_e} - {2'b0, sens2};
    end
  end

endmodule

>>> hdl/baro_press.sv
// baro_press: pressure product in two halves, final sum and output clamp
module baro_press (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              up_valid,
  input  baro_pkg::corr_t   up,
  output logic              dn_valid,
  output baro_pkg::result_t dn
);

  // d1*sens >> 21 = d1*sens_hi + (d1*sens_lo >> 21), sens_lo being the low 21 bits
  logic [20:0]        sens_lo;
  logic signed [19:0] sens_hi;

  assign sens_lo = up.sens_f[20:0];
  assign sens_hi = up.sens_f[40:21];

  // stage g: partial products
  logic               vg;
  logic [44:0]        pl;
  logic signed [44:0] ph;
  logic signed [40:0] off_g;
  logic signed [14:0] temp_g;
  logic               tflag_g;

  // stage h: sum and scale
  logic [46:0]        sum_w;
  logic               vh;
  logic signed [31:0] p;
  logic signed [14:0] temp_h;
  logic               tflag_h;

  assign sum_w = {{2{ph[44]}}, ph} + {23'b0, pl[44:21]} - {{6{off_g[40]}}, off_g};

  always_ff @(posedge clk) begin
    if (rst) begin
      vg       <= 1'b0;
      vh       <= 1'b0;
      dn_valid <= 1'b0;
    end else if (en) begin
      vg       <= up_valid;
      vh       <= vg;
      dn_valid <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl      <= up.d1 * sens_lo;
      ph      <= $signed({1'b0, up.d1}) * sens_hi;
      off_g   <= up.off_f;
      temp_g  <= up.temp_centi;
      tflag_g <= up.temp_flag;

      p       <= sum_w[46:15];
      temp_h  <= temp_g;
      tflag_h <= tflag_g;

      dn.temp_centi <= temp_h;
      if (p < $signed({15'b0, baro_pkg::PRESS_MIN})) begin
        dn.press_centi  <= baro_pkg::PRESS_MIN;
        dn.out_of_range <= 1'b1;
      end else if (p > $signed({15'b0, baro_pkg::PRESS_MAX})) begin
        dn.press_centi  <= baro_pkg::PRESS_MAX;
        dn.out_of_range <= 1'b1;
      end else begin
        dn.press_centi  <= p[16:0];
        dn.out_of_range <= tflag_h;
      end
    end
  end

endmodule

>>> hdl/baro_second_order_compensation_core.sv
// baro_second_order_compensation_core: top level, calibration registers and pipeline
//
//  channel  signals                          carries
//  -------  -------------------------------  ----------------------------------
//  samp     samp_valid, samp_ready, samp     raw pressure and temperature beat
//  res      res_valid, res_ready, res        temperature, pressure, range flag
//  cfg      cfg_valid, cfg_ready, cfg_index, calibration word write, index 0..5
//           cfg_data
//
//  one beat a cycle in, one a cycle out while res is not held; the stages, in
//  order, are dT, products, first-order terms, squares, corrections, subtract,
//  split pressure product, sum and clamp, with multiplies in the products,
//  squares and split pressure product stages
//  the whole pipeline advances together while the output register is empty or
//  being taken; when res is held, every stage holds and samp_ready drops
//  reset clears the valid bits and loads the factory calibration words
//  cfg is always ready; writes to index 6 or 7 are ignored
module baro_second_order_compensation_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              samp_valid,
  output logic              samp_ready,
  input  baro_pkg::sample_t samp,
  output logic              res_valid,
  input  logic              res_ready,
  output baro_pkg::result_t res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  baro_pkg::cal_t   cal;
  baro_pkg::front_t front;
  baro_pkg::corr_t  corr;
  logic             front_valid;
  logic             corr_valid;
  logic             en;

  // global advance: the output register is free or being emptied this cycle
  assign en         = !res_valid || res_ready;
  assign samp_ready = en;
  assign cfg_ready  = 1'b1;

  // calibration words
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.c1 <= baro_pkg::C1_RESET;
      cal.c2 <= baro_pkg::C2_RESET;
      cal.c3 <= baro_pkg::C3_RESET;
      cal.c4 <= baro_pkg::C4_RESET;
      cal.c5 <= baro_pkg::C5_RESET;
      cal.c6 <= baro_pkg::C6_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        baro_pkg::CFG_C1_SENS:      cal.c1 <= cfg_data;
        baro_pkg::CFG_C2_OFFSET:    cal.c2 <= cfg_data;
        baro_pkg::CFG_C3_SENS_TC:   cal.c3 <= cfg_data;
        baro_pkg::CFG_C4_OFFSET_TC: cal.c4 <= cfg_data;
        baro_pkg::CFG_C5_REF_TEMP:  cal.c5 <= cfg_data;
        baro_pkg::CFG_C6_TEMP_COEF: cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // dT and first-order terms
  baro_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cal      (cal),
    .up_valid (samp_valid && samp_ready),
    .up       (samp),
    .dn_valid (front_valid),
    .dn       (front)
  );

  // second-order correction below 20 C and -15 C
  baro_corr u_corr (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (front_valid),
    .up       (front),
    .dn_valid (corr_valid),
    .dn       (corr)
  );

  // pressure and output register
  baro_press u_press (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .up_valid (corr_valid),
    .up       (corr),
    .dn_valid (res_valid),
    .dn       (res)
  );

  // results stay within the clamp bounds
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.temp_centi >= baro_pkg::TEMP_MIN) &&
                  (res.temp_centi <= baro_pkg::TEMP_MAX))
    else $error("temperature beyond clamp bounds");

  a_press_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.press_centi >= baro_pkg::PRESS_MIN) &&
                  (res.press_centi <= baro_pkg::PRESS_MAX))
    else $error("pressure beyond clamp bounds");

  // a result strictly inside every bound was never clamped, so carries no flag
  a_flag_press: assert property (@(posedge clk) disable iff (rst)
    res_valid &&
    (res.temp_centi > baro_pkg::TEMP_MIN) && (res.temp_centi < baro_pkg::TEMP_MAX) &&
    (res.press_centi > baro_pkg::PRESS_MIN) && (res.press_centi < baro_pkg::PRESS_MAX)
    |-> !res.out_of_range)
    else $error("range flag without a clamp");

  // a calibration write to C5 lands in that word
  a_cfg_c5: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == baro_pkg::CFG_C5_REF_TEMP)
    |=> cal.c5 == $past(cfg_data))
    else $error("calibration write lost");

  // nothing leaves the pipeline straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

>>> bench/baro_second_order_compensation_core_tb.sv
// testbench of the barometer compensation core: directed table, then random phases
`timescale 1ns / 1ps

module baro_second_order_compensation_core_tb;

  // spare indexes beyond the calibration list, the core must ignore them
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  localparam int N_DIRECTED   = 20;
  localparam int N_PHASES     = 8;
  localparam int PHASE_BEATS  = 160;
  localparam int DRAIN_CYCLES = 16;    // nine-stage pipe plus some margin
  localparam int HOLD_CYCLES  = 300;   // long enough to back the whole pipe up
  localparam int REPORT_LIMIT = 10;

  // one row of the directed table: the sample, and a typed-in reading where
  // the answer is plain (datasheet example, clamped corners)
  typedef struct packed {
    baro_pkg::sample_t samp;
    logic              typed;
    baro_pkg::result_t known;
  } stim_row_t;

  localparam logic [33:0] BY_PREDICTOR = '0;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // datasheet example with the factory words: 20.07 C, 1000.09 mbar
    {24'd9085466,  24'd8569150,  1'b1, 15'sd2007, 17'd100009, 1'b0},
    // corners of the raw words: both results pinned to a bound
    {24'd0,        24'd16777215, 1'b1, baro_pkg::TEMP_MAX, baro_pkg::PRESS_MIN, 1'b1},
    {24'd16777215, 24'd16777215, 1'b1, baro_pkg::TEMP_MAX, baro_pkg::PRESS_MAX, 1'b1},
    {24'd0,        24'd0,        1'b1, baro_pkg::TEMP_MIN, baro_pkg::PRESS_MAX, 1'b1},
    {24'd16777215, 24'd0,        1'b1, baro_pkg::TEMP_MIN, baro_pkg::PRESS_MIN, 1'b1},
    // dT of zero, then one count below 20 C where the correction starts
    {24'd9085466,  24'd8566784,  BY_PREDICTOR},
    {24'd9085466,  24'd8566783,  BY_PREDICTOR},
    // either side of the -15 C knee
    {24'd9085466,  24'd7529764,  BY_PREDICTOR},
    {24'd9085466,  24'd7529000,  BY_PREDICTOR},
    {24'd9085466,  24'd7531000,  BY_PREDICTOR},
    // zero pressure word treated like any other
    {24'd0,        24'd8569150,  BY_PREDICTOR},
    {24'd8000000,  24'd8400000,  BY_PREDICTOR},
    {24'd8500000,  24'd8700000,  BY_PREDICTOR},
    {24'd7000000,  24'd8000000,  BY_PREDICTOR},
    {24'd16777215, 24'd8569150,  BY_PREDICTOR},
    {24'd1,        24'd1,        BY_PREDICTOR},
    {24'hAAAAAA,   24'h555555,   BY_PREDICTOR},
    {24'h555555,   24'hAAAAAA,   BY_PREDICTOR},
    {24'd9500000,  24'd9000000,  BY_PREDICTOR},
    {24'd8800000,  24'd8200000,  BY_PREDICTOR}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              samp_valid = 1'b0;
  logic              samp_ready;
  baro_pkg::sample_t samp = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  baro_pkg::result_t res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  // calibration words as the core should hold them
  baro_pkg::cal_t cal_now = '{c1: baro_pkg::C1_RESET, c2: baro_pkg::C2_RESET,
                              c3: baro_pkg::C3_RESET, c4: baro_pkg::C4_RESET,
                              c5: baro_pkg::C5_RESET, c6: baro_pkg::C6_RESET};

  baro_pkg::result_t pending_readings [$];
  baro_pkg::result_t oldest_reading;
  int                fail_count = 0;
  int                reported   = 0;

  // idling knobs, in percent, set per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long hold-off: the main flow asks, the receiver counts it out
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;

  always #4 clk = ~clk;

  baro_second_order_compensation_core uut (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp_valid),
    .samp_ready (samp_ready),
    .samp       (samp),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // second-order compensation in exact 64-bit integers; >>> on a signed
  // longint floors, as the datasheet's divisions by powers of two want
  function automatic baro_pkg::result_t compensate(input baro_pkg::sample_t s,
                                                   input baro_pkg::cal_t k);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, off2, sens2, a, b, p;
    logic   clipped;
    baro_pkg::result_t r;
    d1 = s.raw_press;
    d2 = s.raw_temp;
    c1 = k.c1;
    c2 = k.c2;
    c3 = k.c3;
    c4 = k.c4;
    c5 = k.c5;
    c6 = k.c6;
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    clipped = 1'b0;

    dt   = d2 - c5 * 256;
    temp = 2000 + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);

    // below 20 C
    if (temp < 2000) begin
      a     = temp - 2000;
      t2    = (dt * dt) >>> 31;
      off2  = (5 * a * a) >>> 1;
      sens2 = (5 * a * a) >>> 2;
      // below -15 C, on the uncorrected temperature
      if (temp < -1500) begin
        b     = temp + 1500;
        off2  = off2 + 7 * b * b;
        sens2 = sens2 + ((11 * b * b) >>> 1);
      end
    end

    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;

    if (temp < -4000) begin
      temp = -4000;
      clipped = 1'b1;
    end
    if (temp > 8500) begin
      temp = 8500;
      clipped = 1'b1;
    end
    if (p < 1000) begin
      p = 1000;
      clipped = 1'b1;
    end
    if (p > 120000) begin
      p = 120000;
      clipped = 1'b1;
    end

    r.temp_centi   = temp[14:0];
    r.press_centi  = p[16:0];
    r.out_of_range = clipped;
    return r;
  endfunction

  // offer one sample beat; the reading it should give is queued at acceptance
  task automatic send_sample(input baro_pkg::sample_t s, input logic typed,
                             input baro_pkg::result_t known);
    if ($urandom_range(99) < send_idle_pct) begin
      samp_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    samp_valid <= 1'b1;
    samp       <= s;
    @(posedge clk);
    while (!samp_ready) @(posedge clk);
    if (typed)
      pending_readings.push_back(known);
    else
      pending_readings.push_back(compensate(s, cal_now));
  endtask

  // one calibration beat; valid is left high for the next write of a batch
  task automatic write_cal(input logic [2:0] idx, input logic [15:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      baro_pkg::CFG_C1_SENS:      cal_now.c1 = word;
      baro_pkg::CFG_C2_OFFSET:    cal_now.c2 = word;
      baro_pkg::CFG_C3_SENS_TC:   cal_now.c3 = word;
      baro_pkg::CFG_C4_OFFSET_TC: cal_now.c4 = word;
      baro_pkg::CFG_C5_REF_TEMP:  cal_now.c5 = word;
      baro_pkg::CFG_C6_TEMP_COEF: cal_now.c6 = word;
      default: ;
    endcase
  endtask

  // all six words, plus junk to the spare indexes, which must change nothing
  task automatic load_cal(input baro_pkg::cal_t k);
    write_cal(baro_pkg::CFG_C1_SENS, k.c1);
    write_cal(CFG_SPARE_6, 16'($urandom));
    write_cal(baro_pkg::CFG_C2_OFFSET, k.c2);
    write_cal(baro_pkg::CFG_C3_SENS_TC, k.c3);
    write_cal(baro_pkg::CFG_C4_OFFSET_TC, k.c4);
    write_cal(CFG_SPARE_7, 16'($urandom));
    write_cal(baro_pkg::CFG_C5_REF_TEMP, k.c5);
    write_cal(baro_pkg::CFG_C6_TEMP_COEF, k.c6);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every reading, then let the pipe run dry
  task automatic settle();
    samp_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, or a long counted hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES - 1;
      res_ready  <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every reading beat against the oldest one waiting
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_readings.size() == 0) begin
        fail_count++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("unexpected reading: temp %0d press %0d flag %0b",
                   res.temp_centi, res.press_centi, res.out_of_range);
        end
      end else begin
        oldest_reading = pending_readings.pop_front();
        if (res.temp_centi !== oldest_reading.temp_centi ||
            res.press_centi !== oldest_reading.press_centi ||
            res.out_of_range !== oldest_reading.out_of_range) begin
          fail_count++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("mismatch: want temp %0d press %0d flag %0b, got %0d %0d %0b",
                     oldest_reading.temp_centi, oldest_reading.press_centi,
                     oldest_reading.out_of_range, res.temp_centi, res.press_centi,
                     res.out_of_range);
          end
        end
      end
    end
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("baro_second_order_compensation_core verification failed");
    $finish;
  end

  initial begin
    baro_pkg::sample_t s;
    baro_pkg::cal_t    k;
    int                base_temp;
    int                pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table on the factory words left by reset
    for (int i = 0; i < N_DIRECTED; i++)
      send_sample(DIRECTED_ROWS[i].samp, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].known);
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // calibration for this phase: factory, both extremes, a mix, spreads and random words
      case (ph)
        0: k = '{c1: baro_pkg::C1_RESET, c2: baro_pkg::C2_RESET,
                 c3: baro_pkg::C3_RESET, c4: baro_pkg::C4_RESET,
                 c5: baro_pkg::C5_RESET, c6: baro_pkg::C6_RESET};
        1: k = '{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF,
                 c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'hFFFF};
        2: k = '0;
        3: k = '{c1: 16'hFFFF, c2: 16'h0000, c3: 16'hFFFF,
                 c4: 16'h0000, c5: 16'hFFFF, c6: 16'h0000};
        4, 6: k = '{c1: baro_pkg::C1_RESET + 16'($urandom_range(0, 4000)) - 16'd2000,
                    c2: baro_pkg::C2_RESET + 16'($urandom_range(0, 4000)) - 16'd2000,
                    c3: baro_pkg::C3_RESET + 16'($urandom_range(0, 4000)) - 16'd2000,
                    c4: baro_pkg::C4_RESET + 16'($urandom_range(0, 4000)) - 16'd2000,
                    c5: baro_pkg::C5_RESET + 16'($urandom_range(0, 4000)) - 16'd2000,
                    c6: baro_pkg::C6_RESET + 16'($urandom_range(0, 4000)) - 16'd2000};
        default: k = '{c1: 16'($urandom), c2: 16'($urandom), c3: 16'($urandom),
                       c4: 16'($urandom), c5: 16'($urandom), c6: 16'($urandom)};
      endcase
      load_cal(k);

      // idling mix: none, sender idle, receiver stalling, both
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase

      // back-pressure test: receiver holds off while the sender keeps going
      if (ph == 0)
        hold_asked = hold_asked + 1;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // realistic conversions around the reference temperature word
          base_temp = int'(cal_now.c5) * 256 + $urandom_range(0, 4194303) - 2097152;
          if (base_temp < 0)
            base_temp = 0;
          if (base_temp > 16777215)
            base_temp = 16777215;
          s.raw_press = 24'($urandom_range(5000000, 11000000));
          s.raw_temp  = 24'(base_temp);
        end else if (pick < 90) begin
          s.raw_press = 24'($urandom);
          s.raw_temp  = 24'($urandom);
        end else begin
          // raw words at zero or full scale
          s.raw_press = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
          s.raw_temp  = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        end
        send_sample(s, 1'b0, '0);
      end
      settle();
    end

    if (fail_count == 0)
      $display("baro_second_order_compensation_core verification clean");
    else
      $display("baro_second_order_compensation_core verification failed");
    $finish;
  end

endmodule

>>> baro_second_order_compensation_core.f
hdl/baro_pkg.sv
hdl/baro_front.sv
hdl/baro_corr.sv
hdl/baro_press.sv
hdl/baro_second_order_compensation_core.sv
bench/baro_second_order_compensation_core_tb.sv
